[sv/rgpg_pkg.sv]
// ----------------------------------------------------------------------------
// rgpg_pkg
// Shared types and constants of the radial gradient pixel generator.
// ----------------------------------------------------------------------------
`default_nettype none

package rgpg_pkg;

	localparam int CoordW   = 12;
	localparam int DimW     = 13;
	localparam int LevelW   = 16;
	localparam int ModeW    = 3;
	localparam int FracBits = 16;
	localparam int MaxDim   = 4096;
	localparam int QuotW    = 2 * FracBits;
	localparam int SqW      = 2 * DimW;
	localparam int DenW     = 2 * SqW - 3;
	localparam int NumW     = 2 * SqW + 1;
	localparam int RemW     = FracBits + 2;
	localparam int AddrW    = 5;
	localparam int DataW    = 32;

	typedef enum logic [ModeW-1:0] {
		SHAPE_CIRCLE  = 3'd0,
		SHAPE_CORNER  = 3'd1,
		SHAPE_ELLIPSE = 3'd2,
		SHAPE_SQUARE  = 3'd3,
		SHAPE_RECT    = 3'd4
	} shape_t;

	localparam logic [2:0] REG_WIDTH  = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_LOW    = 3'd2;
	localparam logic [2:0] REG_HIGH   = 3'd3;
	localparam logic [2:0] REG_MODE   = 3'd4;

	typedef struct packed {
		logic [NumW-1:0] num;
		logic [DenW-1:0] den;
		logic            sq;
	} setup_t;

	typedef struct packed {
		logic            sat;
		logic            sq;
		logic [DenW-1:0] r;
		logic [DenW-1:0] den;
		logic [QuotW-1:0] q;
	} div_t;

	typedef struct packed {
		logic                sat;
		logic                sq;
		logic [QuotW-1:0]    rad;
		logic [RemW-1:0]     rem;
		logic [FracBits-1:0] root;
		logic [FracBits-1:0] tdiv;
	} sqrt_t;

endpackage

`default_nettype wire

[sv/rgpg_if.sv]
// ----------------------------------------------------------------------------
// pixel_if / level_if
// Valid-ready channels for pixel coordinates and gradient levels.
// ----------------------------------------------------------------------------
`default_nettype none

interface pixel_if;
	logic        valid;
	logic        ready;
	logic [11:0] pixel_x;
	logic [11:0] pixel_y;
	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface level_if;
	logic        valid;
	logic        ready;
	logic [15:0] level;
	modport source (output valid, output level, input ready);
	modport sink (input valid, input level, output ready);
endinterface

`default_nettype wire

[sv/rgpg_setup.sv]
// ----------------------------------------------------------------------------
// rgpg_setup
// Three-stage front end: offsets, squares and cross products, then the
// numerator and denominator of the selected shape.
// ----------------------------------------------------------------------------
`default_nettype none

module rgpg_setup (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [2:0]                en,
	input  wire logic                      vld_i,
	input  wire logic [rgpg_pkg::CoordW-1:0] pixel_x,
	input  wire logic [rgpg_pkg::CoordW-1:0] pixel_y,
	input  wire logic [rgpg_pkg::DimW-1:0] w,
	input  wire logic [rgpg_pkg::DimW-1:0] h,
	input  wire logic [rgpg_pkg::ModeW-1:0] mode,
	output logic [2:0]                     vld_o,
	output rgpg_pkg::setup_t               setup_o
);
	import rgpg_pkg::*;

	logic [DimW-1:0] x2, y2, ax_c, ay_c, d_c;
	logic [DimW-1:0] ax_s1, ay_s1, ax_s2, ay_s2, w_s2, h_s2, d_s2;
	logic [ModeW-1:0] mode_s1, mode_s2;
	logic [SqW-1:0] ax2_s2, ay2_s2, w2_s2, h2_s2, d2_s2, axh_s2, ayw_s2;
	logic [2*SqW-1:0] ell_x_c, ell_y_c, ell_d_c;
	logic [2:0] vld_q;
	setup_t setup_c, setup_s3;

	assign x2   = {pixel_x, 1'b0};
	assign y2   = {pixel_y, 1'b0};
	assign ax_c = (x2 >= w) ? x2 - w : w - x2;
	assign ay_c = (y2 >= h) ? y2 - h : h - y2;
	assign d_c  = (w < h) ? w : h;

	// full-width ellipse products
	assign ell_x_c = (2*SqW)'(ax2_s2) * (2*SqW)'(h2_s2);
	assign ell_y_c = (2*SqW)'(ay2_s2) * (2*SqW)'(w2_s2);
	assign ell_d_c = (2*SqW)'(w2_s2) * (2*SqW)'(h2_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) vld_q[0] <= vld_i;
			if (en[1]) vld_q[1] <= vld_q[0];
			if (en[2]) vld_q[2] <= vld_q[1];
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ax_s1   <= ax_c;
			ay_s1   <= ay_c;
			mode_s1 <= mode;
		end
		if (en[1]) begin
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
			mode_s2 <= mode_s1;
			w_s2    <= w;
			h_s2    <= h;
			d_s2    <= d_c;
			ax2_s2  <= ax_s1 * ax_s1;
			ay2_s2  <= ay_s1 * ay_s1;
			w2_s2   <= w * w;
			h2_s2   <= h * h;
			d2_s2   <= d_c * d_c;
			axh_s2  <= ax_s1 * h;
			ayw_s2  <= ay_s1 * w;
		end
		if (en[2]) setup_s3 <= setup_c;
	end

	always_comb begin
		setup_c.num = '0;
		setup_c.den = DenW'(1);
		setup_c.sq  = 1'b0;
		case (mode_s2)
			SHAPE_CIRCLE: begin
				setup_c.num = NumW'(ax2_s2) + NumW'(ay2_s2);
				setup_c.den = DenW'(d2_s2);
				setup_c.sq  = 1'b1;
			end
			SHAPE_CORNER: begin
				setup_c.num = NumW'(ax2_s2) + NumW'(ay2_s2);
				setup_c.den = DenW'(w2_s2) + DenW'(h2_s2);
				setup_c.sq  = 1'b1;
			end
			SHAPE_ELLIPSE: begin
				setup_c.num = NumW'(ell_x_c) + NumW'(ell_y_c);
				setup_c.den = DenW'(ell_d_c);
				setup_c.sq  = 1'b1;
			end
			SHAPE_SQUARE: begin
				setup_c.num = NumW'((ax_s2 > ay_s2) ? ax_s2 : ay_s2);
				setup_c.den = DenW'(d_s2);
			end
			SHAPE_RECT: begin
				if (axh_s2 >= ayw_s2) begin
					setup_c.num = NumW'(ax_s2);
					setup_c.den = DenW'(w_s2);
				end else begin
					setup_c.num = NumW'(ay_s2);
					setup_c.den = DenW'(h_s2);
				end
			end
			default: begin
				setup_c.num = '0;
				setup_c.den = DenW'(1);
			end
		endcase
	end

	assign vld_o   = vld_q;
	assign setup_o = setup_s3;

endmodule

`default_nettype wire

[sv/rgpg_div_cell.sv]
// ----------------------------------------------------------------------------
// rgpg_div_cell
// One restoring division step: produces one quotient bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module rgpg_div_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           vld_i,
	input  rgpg_pkg::div_t      d_i,
	output logic                vld_o,
	output rgpg_pkg::div_t      d_o
);
	import rgpg_pkg::*;

	logic [DenW:0] r2, diff;
	logic          take;
	div_t          nxt, d_q;
	logic          vld_q;

	assign r2   = {d_i.r, 1'b0};
	assign diff = r2 - {1'b0, d_i.den};
	assign take = r2 >= {1'b0, d_i.den};

	always_comb begin
		nxt   = d_i;
		nxt.r = take ? diff[DenW-1:0] : r2[DenW-1:0];
		nxt.q = {d_i.q[QuotW-2:0], take};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) d_q <= nxt;
	end

	assign vld_o = vld_q;
	assign d_o   = d_q;

endmodule

`default_nettype wire

[sv/rgpg_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// rgpg_sqrt_cell
// One digit-by-digit square root step: produces one root bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module rgpg_sqrt_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           vld_i,
	input  rgpg_pkg::sqrt_t     s_i,
	output logic                vld_o,
	output rgpg_pkg::sqrt_t     s_o
);
	import rgpg_pkg::*;

	logic [RemW+1:0] rem_sh, trial, diff;
	logic            take;
	sqrt_t           nxt, s_q;
	logic            vld_q;

	assign rem_sh = {s_i.rem, s_i.rad[QuotW-1:QuotW-2]};
	assign trial  = (RemW+2)'({s_i.root, 2'b01});
	assign diff   = rem_sh - trial;
	assign take   = rem_sh >= trial;

	always_comb begin
		nxt      = s_i;
		nxt.rad  = {s_i.rad[QuotW-3:0], 2'b00};
		nxt.rem  = take ? diff[RemW-1:0] : rem_sh[RemW-1:0];
		nxt.root = {s_i.root[FracBits-2:0], take};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) s_q <= nxt;
	end

	assign vld_o = vld_q;
	assign s_o   = s_q;

endmodule

`default_nettype wire

[sv/radial_gradient_pixel_generator.sv]
// ----------------------------------------------------------------------------
// radial_gradient_pixel_generator
// Maps a pixel coordinate to a radial, elliptic or box gradient level.
// ----------------------------------------------------------------------------
// Usage:
//   pixel_in carries pixel_x/pixel_y, level_out returns one level for each
//   transfer, in order. Both are valid/ready channels.
//   The APB port holds frame width, height, low and high levels and shape
//   mode at byte addresses 0, 4, 8, 12, 16; write them only while idle.
//   From input transfer to output valid an item passes three setup
//   stages, a row of 32 division cells (one quotient bit each), a row of 16
//   square root cells (one root bit each), and two stages for the scaling
//   multiply and the output register.
//   Throughput is one pixel per cycle while level_out does not stall; every
//   stage hands its item on each cycle that it is enabled.
//   When level_out stalls, the pipeline keeps filling its empty stages, so
//   pixel_in keeps taking transfers until every stage holds an item.
//   Reset clears all stage valids and loads the register defaults
//   (256 x 256, low 0, high 255, circle).
// ----------------------------------------------------------------------------
`default_nettype none

module radial_gradient_pixel_generator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	pixel_if.sink            pixel_in,
	level_if.source          level_out,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [rgpg_pkg::AddrW-1:0] paddr,
	input  wire logic [rgpg_pkg::DataW-1:0] pwdata,
	output logic [rgpg_pkg::DataW-1:0]      prdata,
	output logic             pready
);
	import rgpg_pkg::*;

	localparam int NDiv  = QuotW;
	localparam int NSqrt = FracBits;

	logic [DimW-1:0]     width_q, height_q, w_c, h_c;
	logic [LevelW-1:0]   low_q, high_q;
	logic [ModeW-1:0]    mode_q;
	logic                wr;

	// config registers
	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DimW'(256);
			height_q <= DimW'(256);
			low_q    <= '0;
			high_q   <= LevelW'(255);
			mode_q   <= '0;
		end else if (wr) begin
			case (paddr[4:2])
				REG_WIDTH:  width_q  <= pwdata[DimW-1:0];
				REG_HEIGHT: height_q <= pwdata[DimW-1:0];
				REG_LOW:    low_q    <= pwdata[LevelW-1:0];
				REG_HIGH:   high_q   <= pwdata[LevelW-1:0];
				REG_MODE:   mode_q   <= pwdata[ModeW-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_WIDTH:  prdata = DataW'(width_q);
			REG_HEIGHT: prdata = DataW'(height_q);
			REG_LOW:    prdata = DataW'(low_q);
			REG_HIGH:   prdata = DataW'(high_q);
			REG_MODE:   prdata = DataW'(mode_q);
			default:    prdata = '0;
		endcase
	end

	assign w_c = (width_q == '0) ? DimW'(1) :
		(width_q > DimW'(MaxDim)) ? DimW'(MaxDim) : width_q;
	assign h_c = (height_q == '0) ? DimW'(1) :
		(height_q > DimW'(MaxDim)) ? DimW'(MaxDim) : height_q;

	// stage enables
	logic [2:0]       en_set, vld_set;
	logic [NDiv-1:0]  en_div, vld_div;
	logic [NSqrt-1:0] en_sq, vld_sq;
	logic             en_l1, en_l2, vld_l1, vld_l2;

	assign en_l2 = !vld_l2 || level_out.ready;
	assign en_l1 = !vld_l1 || en_l2;

	always_comb begin
		en_sq[NSqrt-1] = !vld_sq[NSqrt-1] || en_l1;
		for (int i = NSqrt - 2; i >= 0; i--) en_sq[i] = !vld_sq[i] || en_sq[i+1];
		en_div[NDiv-1] = !vld_div[NDiv-1] || en_sq[0];
		for (int i = NDiv - 2; i >= 0; i--) en_div[i] = !vld_div[i] || en_div[i+1];
		en_set[2] = !vld_set[2] || en_div[0];
		en_set[1] = !vld_set[1] || en_set[2];
		en_set[0] = !vld_set[0] || en_set[1];
	end

	assign pixel_in.ready = en_set[0];

	// front end
	setup_t setup;

	rgpg_setup u_setup (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en_set),
		.vld_i   (pixel_in.valid),
		.pixel_x (pixel_in.pixel_x),
		.pixel_y (pixel_in.pixel_y),
		.w       (w_c),
		.h       (h_c),
		.mode    (mode_q),
		.vld_o   (vld_set),
		.setup_o (setup)
	);

	// division row
	div_t div_in;
	div_t div_d [NDiv];
	logic sat0;

	assign sat0       = setup.num >= NumW'(setup.den);
	assign div_in.sat = sat0;
	assign div_in.sq  = setup.sq;
	assign div_in.r   = sat0 ? '0 : setup.num[DenW-1:0];
	assign div_in.den = setup.den;
	assign div_in.q   = '0;

	for (genvar g = 0; g < NDiv; g++) begin : g_div
		rgpg_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en_div[g]),
			.vld_i  ((g == 0) ? vld_set[2] : vld_div[(g == 0) ? 0 : g-1]),
			.d_i    ((g == 0) ? div_in : div_d[(g == 0) ? 0 : g-1]),
			.vld_o  (vld_div[g]),
			.d_o    (div_d[g])
		);
	end

	// square root row
	sqrt_t sq_in;
	sqrt_t sq_d [NSqrt];

	assign sq_in.sat  = div_d[NDiv-1].sat;
	assign sq_in.sq   = div_d[NDiv-1].sq;
	assign sq_in.rad  = div_d[NDiv-1].q;
	assign sq_in.rem  = '0;
	assign sq_in.root = '0;
	assign sq_in.tdiv = div_d[NDiv-1].q[QuotW-1:QuotW-FracBits];

	for (genvar g = 0; g < NSqrt; g++) begin : g_sqrt
		rgpg_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en_sq[g]),
			.vld_i  ((g == 0) ? vld_div[NDiv-1] : vld_sq[(g == 0) ? 0 : g-1]),
			.s_i    ((g == 0) ? sq_in : sq_d[(g == 0) ? 0 : g-1]),
			.vld_o  (vld_sq[g]),
			.s_o    (sq_d[g])
		);
	end

	// scaling and output
	logic [FracBits:0]              t_c;
	logic signed [LevelW:0]         diff_c;
	logic signed [LevelW+FracBits+1:0] diff_w, t_w;
	logic signed [LevelW+FracBits+1:0] prod_s1;
	logic [LevelW-1:0]              level_s2;
	logic signed [LevelW+FracBits+1:0] lvl_c;

	assign t_c = sq_d[NSqrt-1].sat ? (FracBits+1)'(1 << FracBits) :
		sq_d[NSqrt-1].sq ? {1'b0, sq_d[NSqrt-1].root} : {1'b0, sq_d[NSqrt-1].tdiv};
	assign diff_c = $signed({1'b0, high_q}) - $signed({1'b0, low_q});
	assign diff_w = {{(FracBits+1){diff_c[LevelW]}}, diff_c};
	assign t_w    = {{(LevelW+1){1'b0}}, t_c};
	assign lvl_c  = (prod_s1 >>> FracBits) + $signed((LevelW+FracBits+2)'(low_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_l1 <= 1'b0;
			vld_l2 <= 1'b0;
		end else begin
			if (en_l1) vld_l1 <= vld_sq[NSqrt-1];
			if (en_l2) vld_l2 <= vld_l1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_l1) prod_s1 <= diff_w * t_w;
		if (en_l2) level_s2 <= lvl_c[LevelW-1:0];
	end

	assign level_out.valid = vld_l2;
	assign level_out.level = level_s2;

	// checks
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!level_out.valid |-> pixel_in.ready)
		else $error("input stalled with empty output stage");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_in.valid && pixel_in.ready |=> vld_set[0])
		else $error("accepted pixel missing from first stage");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		vld_l1 && !vld_l2 |=> vld_l2)
		else $error("result did not reach output register");

endmodule

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for radial_gradient_pixel_generator: pixels go in over a
// valid/ready channel with random gaps, levels come back under random stalls
// and are compared in order with a built-in gradient calculator. Shape modes,
// frame sizes and level ranges are changed over the APB port between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import rgpg_pkg::*;

	localparam int DrainCycles = 64;
	localparam int CycleLimit  = 400000;

	logic             clk;
	logic             arst_n;
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [AddrW-1:0] paddr;
	logic [DataW-1:0] pwdata;
	logic [DataW-1:0] prdata;
	logic             pready;

	pixel_if pix ();
	level_if lvl ();

	radial_gradient_pixel_generator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel_in  (pix),
		.level_out (lvl),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	logic [DimW-1:0]   cfg_width;
	logic [DimW-1:0]   cfg_height;
	logic [LevelW-1:0] cfg_low;
	logic [LevelW-1:0] cfg_high;
	logic [ModeW-1:0]  cfg_mode;

	logic [LevelW-1:0] level_queue[$];
	int                mismatches;
	int                cycles;
	int                stall_left;
	bit                idle_on;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic logic [63:0] clip_dim(logic [DimW-1:0] v);
		if (v == 0)
			return 64'd1;
		if (v > MaxDim)
			return 64'(MaxDim);
		return 64'(v);
	endfunction

	function automatic logic [63:0] frac_root(logic [127:0] num, logic [127:0] den);
		logic [127:0] t;
		logic [127:0] c;
		if (num >= den)
			return 64'd1 << FracBits;
		t = '0;
		for (int b = FracBits - 1; b >= 0; b--) begin
			c = t | (128'd1 << b);
			if (c * c * den <= (num << (2 * FracBits)))
				t = c;
		end
		return t[63:0];
	endfunction

	function automatic logic [LevelW-1:0] gradient_level(logic [11:0] x, logic [11:0] y);
		logic [63:0] w, h, d, x2, y2, ax, ay, t, ta, tb;
		logic [127:0] w2, h2;
		longint diff, prod, lv;
		w  = clip_dim(cfg_width);
		h  = clip_dim(cfg_height);
		d  = (w < h) ? w : h;
		x2 = 64'(x) * 2;
		y2 = 64'(y) * 2;
		ax = (x2 >= w) ? x2 - w : w - x2;
		ay = (y2 >= h) ? y2 - h : h - y2;
		w2 = 128'(w) * w;
		h2 = 128'(h) * h;
		case (cfg_mode)
			SHAPE_CIRCLE: t = frac_root(128'(ax * ax + ay * ay), 128'(d * d));
			SHAPE_CORNER: t = frac_root(128'(ax * ax + ay * ay), w2 + h2);
			SHAPE_ELLIPSE: t = frac_root(128'(ax * ax) * h2 + 128'(ay * ay) * w2, w2 * h2);
			SHAPE_SQUARE: t = (((ax > ay) ? ax : ay) << FracBits) / d;
			SHAPE_RECT: begin
				ta = (ax << FracBits) / w;
				tb = (ay << FracBits) / h;
				t  = (ta > tb) ? ta : tb;
			end
			default: t = 0;
		endcase
		if (t > (64'd1 << FracBits))
			t = 64'd1 << FracBits;
		diff = longint'(cfg_high) - longint'(cfg_low);
		prod = diff * longint'(t);
		if (prod >= 0)
			lv = prod >>> FracBits;
		else
			lv = -((-prod + (64'sd1 << FracBits) - 1) >>> FracBits);
		lv = lv + longint'(cfg_low);
		return lv[LevelW-1:0];
	endfunction

	// level sink: random stalls, checked on the falling edge before the transfer edge
	always @(posedge clk) begin
		if (stall_left > 0) begin
			lvl.ready <= 1'b0;
			stall_left--;
		end else begin
			lvl.ready <= 1'b1;
			if (idle_on && $urandom_range(0, 7) == 0)
				stall_left = gap_len();
		end
	end

	always @(negedge clk) begin
		if (arst_n && lvl.valid && lvl.ready) begin
			if (level_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected level %0d", lvl.level);
			end else begin
				if (lvl.level !== level_queue[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("level mismatch: expected %0d actual %0d",
							level_queue[0], lvl.level);
				end
				void'(level_queue.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_pixel(logic [11:0] x, logic [11:0] y);
		int gap;
		gap = idle_on ? gap_len() : 0;
		if (gap > 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix.valid   <= 1'b1;
		pix.pixel_x <= x;
		pix.pixel_y <= y;
		do
			@(negedge clk);
		while (!pix.ready);
		level_queue.push_back(gradient_level(x, y));
		@(posedge clk);
	endtask

	task automatic wait_idle();
		pix.valid <= 1'b0;
		while (level_queue.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [DataW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= AddrW'(idx) << 2;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_WIDTH: cfg_width = value[DimW-1:0];
			REG_HEIGHT: cfg_height = value[DimW-1:0];
			REG_LOW: cfg_low = value[LevelW-1:0];
			REG_HIGH: cfg_high = value[LevelW-1:0];
			REG_MODE: cfg_mode = value[ModeW-1:0];
			default: ;
		endcase
	endtask

	task automatic set_frame(int w, int h, int lo, int hi, logic [ModeW-1:0] mode);
		wait_idle();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_LOW, lo);
		write_reg(REG_HIGH, hi);
		write_reg(REG_MODE, mode);
	endtask

	function automatic logic [11:0] pick_coord(logic [DimW-1:0] dim);
		logic [63:0] n;
		n = clip_dim(dim);
		if ($urandom_range(0, 9) < 8 && n <= 4096)
			return 12'($urandom_range(0, int'(n) - 1));
		return 12'($urandom_range(0, 4095));
	endfunction

	task automatic test_reset_defaults();
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd128, 12'd128);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd200, 12'd37);
		send_pixel(12'hAAA, 12'h555);
	endtask

	task automatic test_special_cases();
		set_frame(0, 8191, 100, 60000, SHAPE_SQUARE);
		send_pixel(12'd0, 12'd2048);
		send_pixel(12'd3, 12'd4095);
		set_frame(4096, 4096, 65535, 0, SHAPE_ELLIPSE);
		send_pixel(12'd2048, 12'd2048);
		send_pixel(12'd1000, 12'd3333);
		send_pixel(12'd4095, 12'd0);
		set_frame(640, 17, 65535, 1, SHAPE_CORNER);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd321, 12'd9);
		set_frame(7, 4000, 5, 300, SHAPE_RECT);
		send_pixel(12'd6, 12'd2000);
		send_pixel(12'd9, 12'd100);
		set_frame(1, 1, 0, 65535, 3'd7);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		wait_idle();
		write_reg(REG_MODE, 5);
		send_pixel(12'd77, 12'd1);
		set_frame(300, 100, 40, 41, SHAPE_CIRCLE);
		send_pixel(12'd150, 12'd50);
		send_pixel(12'd299, 12'd99);
	endtask

	task automatic test_random_phases();
		int w, h;
		for (int p = 0; p < 10; p++) begin
			idle_on = (p != 4);
			w = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 600);
			h = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 600);
			set_frame(w, h, $urandom_range(0, 65535), $urandom_range(0, 65535),
				(p < 5) ? ModeW'(p) : ModeW'($urandom_range(0, 7)));
			for (int i = 0; i < 42; i++)
				send_pixel(pick_coord(cfg_width), pick_coord(cfg_height));
		end
		idle_on = 1'b1;
	endtask

	task automatic test_pipeline_drain();
		set_frame(255, 4096, 0, 65535, SHAPE_ELLIPSE);
		for (int i = 0; i < 20; i++)
			send_pixel(pick_coord(cfg_width), pick_coord(cfg_height));
		pix.valid <= 1'b0;
		while (level_queue.size() != 0)
			@(posedge clk);
		for (int i = 0; i < 20; i++)
			send_pixel(pick_coord(cfg_width), pick_coord(cfg_height));
	endtask

	initial begin
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		pix.valid   = 1'b0;
		pix.pixel_x = '0;
		pix.pixel_y = '0;
		lvl.ready   = 1'b0;
		cfg_width   = 13'd256;
		cfg_height  = 13'd256;
		cfg_low     = 16'd0;
		cfg_high    = 16'd255;
		cfg_mode    = SHAPE_CIRCLE;
		mismatches  = 0;
		cycles      = 0;
		stall_left  = 0;
		idle_on     = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_special_cases();
		test_random_phases();
		test_pipeline_drain();
		wait_idle();

		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
sv/rgpg_pkg.sv
sv/rgpg_if.sv
sv/rgpg_setup.sv
sv/rgpg_div_cell.sv
sv/rgpg_sqrt_cell.sv
sv/radial_gradient_pixel_generator.sv
tb/testbench.sv
